[sv/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg
// Types and constants shared by the scheduler and sync engine.
// ----------------------------------------------------------------------------
package rss_pkg;

   localparam int TASK_SLOTS      = 8;
   localparam int SEMAPHORE_SLOTS = 8;
   localparam int QUEUE_SLOTS     = 4;
   localparam int QUEUE_DEPTH     = 16;

   localparam int TW  = $clog2(TASK_SLOTS);
   localparam int SW  = $clog2(SEMAPHORE_SLOTS);
   localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
   localparam int DW  = $clog2(QUEUE_DEPTH);

   // request codes
   localparam logic [3:0] REQ_NEW_TASK  = 4'd0;
   localparam logic [3:0] REQ_SEM_NEW   = 4'd1;
   localparam logic [3:0] REQ_SEM_POST  = 4'd2;
   localparam logic [3:0] REQ_SEM_PEND  = 4'd3;
   localparam logic [3:0] REQ_QUE_NEW   = 4'd4;
   localparam logic [3:0] REQ_QUE_POST  = 4'd5;
   localparam logic [3:0] REQ_QUE_PEND  = 4'd6;
   localparam logic [3:0] REQ_ISR_ENTER = 4'd7;
   localparam logic [3:0] REQ_ISR_EXIT  = 4'd8;
   localparam logic [3:0] REQ_RUN       = 4'd9;

   // task states
   localparam logic [1:0] ST_READY  = 2'd0;
   localparam logic [1:0] ST_SEM    = 2'd1;
   localparam logic [1:0] ST_QUEUE  = 2'd2;
   localparam logic [1:0] ST_UNUSED = 2'd3;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [2:0]  object_index;
      logic [7:0]  init_value;
      logic [4:0]  new_queue_size;
      logic [15:0] message_in;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  running_id;
      logic        running_ok;
      logic        switched;
      logic [2:0]  handle_out;
      logic [15:0] message_out;
      logic        blocked;
      logic        fault;
   } rsp_word_type;

endpackage

[sv/rss_req_if.sv]
// ----------------------------------------------------------------------------
// rss_req_if
// Request channel: valid, ready and one request word.
// ----------------------------------------------------------------------------
interface rss_req_if import rss_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/rss_rsp_if.sv]
// ----------------------------------------------------------------------------
// rss_rsp_if
// Response channel: valid, ready and one response word.
// ----------------------------------------------------------------------------
interface rss_rsp_if import rss_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/rtos_scheduler_sync_engine.sv]
// Flow: an accepted request waits in the front queue, is fetched, then executed.
// The engine takes one request at a time: it pops no new request until the
// read/update pair on the semaphore and queue memories is done.
// Reset: synchronous, active high; all tasks unused, all tables empty.
// ----------------------------------------------------------------------------
// rtos_scheduler_sync_engine
// Hardware priority scheduler with semaphores and message queues.
// ----------------------------------------------------------------------------
module rtos_scheduler_sync_engine import rss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rss_req_if.sink  req,
   rss_rsp_if.source rsp
);

   logic         q_valid, q_pop;
   req_word_type q_data;

   rss_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   rss_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(rsp)
   );

endmodule

[sv/rss_front.sv]
// ----------------------------------------------------------------------------
// rss_front
// Accepts request words into a two-entry queue toward the kernel engine.
// ----------------------------------------------------------------------------
module rss_front import rss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rss_req_if.sink      req,
   output logic         q_valid,
   output req_word_type q_data,
   input  logic         q_pop
);

   req_word_type buf_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = buf_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) buf_ff[wr_ff] <= req.data;
   end

endmodule

[sv/rss_back.sv]
// ----------------------------------------------------------------------------
// rss_back
// Executes kernel requests: reads objects in the fetch phase, updates them in the execute phase.
// ----------------------------------------------------------------------------
module rss_back import rss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  req_word_type q_data,
   output logic         q_pop,
   rss_rsp_if.source    rsp
);

   localparam logic PH_FETCH = 1'b0;
   localparam logic PH_EXEC  = 1'b1;

   // task table
   logic [1:0]      status_ff [TASK_SLOTS];
   logic [1:0]      status_in [TASK_SLOTS];
   logic [2:0]      wobj_ff   [TASK_SLOTS];
   logic [2:0]      wobj_in   [TASK_SLOTS];
   logic [TW:0]     ttot_ff, ttot_in;
   logic [TW-1:0]   run_ff, run_in;
   logic            runv_ff, runv_in;
   logic [7:0]      isr_ff, isr_in;
   logic [SW:0]     stot_ff, stot_in;
   logic [QW:0]     qtot_ff, qtot_in;
   logic [DW-1:0]   rix_ff [QUEUE_SLOTS];
   logic [DW-1:0]   rix_in [QUEUE_SLOTS];
   logic [DW-1:0]   wix_ff [QUEUE_SLOTS];
   logic [DW-1:0]   wix_in [QUEUE_SLOTS];
   logic [DW:0]     qlen_ff [QUEUE_SLOTS];
   logic [DW:0]     qlen_in [QUEUE_SLOTS];

   // memories
   logic [7:0]      sem_mem [SEMAPHORE_SLOTS];
   logic [15:0]     que_mem [QUEUE_SLOTS*QUEUE_DEPTH];

   logic            ph_ff, ph_in;
   req_word_type    cur_ff;
   logic [7:0]      semrd_ff;
   logic [15:0]     querd_ff;
   logic            ov_ff, ov_in;
   rsp_word_type    out_ff, out_in;

   logic            sem_we;
   logic [7:0]      sem_wd;
   logic            que_we;
   logic [QW+DW-1:0] que_wa, que_ra;

   logic [SW-1:0]   sidx;
   logic [QW-1:0]   qidx;
   logic            sem_ok, que_ok;

   assign sidx = cur_ff.object_index[SW-1:0];
   assign qidx = cur_ff.object_index[QW-1:0];
   assign sem_ok = (32'(cur_ff.object_index) < 32'(stot_ff));
   assign que_ok = (32'(cur_ff.object_index) < 32'(qtot_ff));

   assign q_pop     = (ph_ff == PH_FETCH) && q_valid && (!ov_ff || rsp.ready);
   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;
   assign que_ra    = {q_data.object_index[QW-1:0],
                       rix_ff[q_data.object_index[QW-1:0]]};

   // request execution
   always_comb begin
      logic [TW-1:0] pick;
      logic          found;
      logic          sch;
      logic          wk;
      logic [1:0]    wkind;
      logic [DW:0]   nx;
      logic [4:0]    qs;
      logic          f, sw, blk;
      logic [2:0]    h;
      logic [15:0]   mo;
      logic [7:0]    v;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         status_in[i] = status_ff[i];
         wobj_in[i]   = wobj_ff[i];
      end
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         rix_in[i]  = rix_ff[i];
         wix_in[i]  = wix_ff[i];
         qlen_in[i] = qlen_ff[i];
      end
      ttot_in = ttot_ff; run_in = run_ff; runv_in = runv_ff;
      isr_in = isr_ff; stot_in = stot_ff; qtot_in = qtot_ff;
      sem_we = 1'b0; sem_wd = semrd_ff;
      que_we = 1'b0; que_wa = {qidx, wix_ff[qidx]};
      sch = 1'b0; wk = 1'b0; wkind = ST_SEM;
      f = 1'b0; sw = 1'b0; blk = 1'b0; h = 3'd0; mo = 16'd0;
      v = semrd_ff; nx = '0; qs = cur_ff.new_queue_size;
      pick = '0; found = 1'b0;
      ph_in = ph_ff;
      ov_in = ov_ff && !rsp.ready;
      out_in = out_ff;
      if (ph_ff == PH_FETCH) begin
         if (q_pop) ph_in = PH_EXEC;
      end else begin
         ph_in = PH_FETCH;
         ov_in = 1'b1;
         case (cur_ff.req_type)
            REQ_NEW_TASK: begin
               if (ttot_ff >= (TW+1)'(TASK_SLOTS)) f = 1'b1;
               else begin
                  h = 3'(ttot_ff);
                  status_in[ttot_ff[TW-1:0]] = ST_READY;
                  wobj_in[ttot_ff[TW-1:0]]   = 3'd0;
                  ttot_in = ttot_ff + 1'b1;
               end
            end
            REQ_SEM_NEW: begin
               if (stot_ff >= (SW+1)'(SEMAPHORE_SLOTS)) f = 1'b1;
               else begin
                  h = 3'(stot_ff);
                  sem_we = 1'b1; sem_wd = cur_ff.init_value;
                  stot_in = stot_ff + 1'b1;
               end
            end
            REQ_SEM_POST: begin
               if (!sem_ok) f = 1'b1;
               else begin
                  sem_we = 1'b1;
                  sem_wd = (v == 8'sd127) ? v : v + 8'd1;
                  wk = 1'b1; wkind = ST_SEM; sch = 1'b1;
               end
            end
            REQ_SEM_PEND: begin
               if (!sem_ok || !runv_ff) f = 1'b1;
               else begin
                  sem_we = 1'b1;
                  sem_wd = (v == 8'h80) ? v : v - 8'd1;
                  if ($signed(v) <= 8'sd0) begin
                     status_in[run_ff] = ST_SEM;
                     wobj_in[run_ff]   = cur_ff.object_index;
                     blk = 1'b1; sch = 1'b1;
                  end
               end
            end
            REQ_QUE_NEW: begin
               if (qtot_ff >= (QW+1)'(QUEUE_SLOTS)) f = 1'b1;
               else begin
                  if (qs == 5'd0) qs = 5'd1;
                  if ({27'd0, qs} > QUEUE_DEPTH) qs = 5'(QUEUE_DEPTH);
                  h = 3'(qtot_ff);
                  qlen_in[qtot_ff[QW-1:0]] = (DW+1)'(qs);
                  rix_in[qtot_ff[QW-1:0]]  = '0;
                  wix_in[qtot_ff[QW-1:0]]  = '0;
                  qtot_in = qtot_ff + 1'b1;
               end
            end
            REQ_QUE_POST: begin
               if (!que_ok) f = 1'b1;
               else begin
                  que_we = 1'b1;
                  nx = {1'b0, wix_ff[qidx]} + 1'b1;
                  wix_in[qidx] = (nx < qlen_ff[qidx]) ? nx[DW-1:0] : '0;
                  wk = 1'b1; wkind = ST_QUEUE; sch = 1'b1;
               end
            end
            REQ_QUE_PEND: begin
               if (!que_ok || !runv_ff) f = 1'b1;
               else if (rix_ff[qidx] == wix_ff[qidx]) begin
                  status_in[run_ff] = ST_QUEUE;
                  wobj_in[run_ff]   = cur_ff.object_index;
                  blk = 1'b1; sch = 1'b1;
               end else begin
                  mo = querd_ff;
                  nx = {1'b0, rix_ff[qidx]} + 1'b1;
                  rix_in[qidx] = (nx < qlen_ff[qidx]) ? nx[DW-1:0] : '0;
               end
            end
            REQ_ISR_ENTER: if (isr_ff != 8'hFF) isr_in = isr_ff + 8'd1;
            REQ_ISR_EXIT: begin
               if (isr_ff != 8'h00) isr_in = isr_ff - 8'd1;
               sch = 1'b1;
            end
            REQ_RUN: sch = 1'b1;
            default: ;
         endcase
         // wake the highest-index waiter on this object
         if (wk) begin
            found = 1'b0;
            for (int i = TASK_SLOTS-1; i >= 0; i--) begin
               if (!found && status_ff[i] == wkind
                   && wobj_ff[i] == cur_ff.object_index) begin
                  found = 1'b1;
                  status_in[i] = ST_READY;
               end
            end
         end
         // priority encode over ready tasks
         if (sch && isr_in == 8'd0) begin
            found = 1'b0;
            for (int i = TASK_SLOTS-1; i >= 0; i--) begin
               if (!found && status_in[i] == ST_READY) begin
                  found = 1'b1;
                  pick = TW'(i);
               end
            end
            if (found) begin
               sw = !runv_ff || (run_ff != pick);
               run_in = pick; runv_in = 1'b1;
            end else begin
               run_in = '0; runv_in = 1'b0; f = 1'b1;
            end
         end
         out_in.running_id  = runv_in ? 3'(run_in) : 3'd0;
         out_in.running_ok  = runv_in;
         out_in.switched    = sw;
         out_in.handle_out  = h;
         out_in.message_out = mo;
         out_in.blocked     = blk;
         out_in.fault       = f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i] <= ST_UNUSED;
            wobj_ff[i]   <= 3'd0;
         end
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            rix_ff[i] <= '0;
            wix_ff[i] <= '0;
         end
         ttot_ff <= '0; run_ff <= '0; runv_ff <= 1'b0; isr_ff <= 8'd0;
         stot_ff <= '0; qtot_ff <= '0; ph_ff <= PH_FETCH; ov_ff <= 1'b0;
      end else begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i] <= status_in[i];
            wobj_ff[i]   <= wobj_in[i];
         end
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            rix_ff[i] <= rix_in[i];
            wix_ff[i] <= wix_in[i];
         end
         ttot_ff <= ttot_in; run_ff <= run_in; runv_ff <= runv_in;
         isr_ff <= isr_in; stot_ff <= stot_in; qtot_ff <= qtot_in;
         ph_ff <= ph_in; ov_ff <= ov_in;
      end
      for (int i = 0; i < QUEUE_SLOTS; i++) qlen_ff[i] <= qlen_in[i];
      out_ff <= out_in;
      if (q_pop) begin
         cur_ff   <= q_data;
         semrd_ff <= sem_mem[q_data.object_index[SW-1:0]];
         querd_ff <= que_mem[que_ra];
      end
      if (sem_we) begin
         if (cur_ff.req_type == REQ_SEM_NEW) sem_mem[stot_ff[SW-1:0]] <= sem_wd;
         else sem_mem[sidx] <= sem_wd;
      end
      if (que_we) que_mem[que_wa] <= cur_ff.message_in;
   end

endmodule

[tb/tb_rtos_scheduler_sync_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtos_scheduler_sync_engine
// Drives kernel requests (task, semaphore and queue creation, post, pend,
// interrupt nesting, scheduler runs) into the engine, predicts each response
// word from a behavioral copy of the scheduler state and compares field by
// field, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_rtos_scheduler_sync_engine;
   import rss_pkg::*;

   logic clock;
   logic reset;

   rss_req_if req ();
   rss_rsp_if rsp ();

   rtos_scheduler_sync_engine i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // clock, 8 ns period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scheduler model state
   logic [1:0]  task_state [TASK_SLOTS];
   logic [2:0]  task_obj [TASK_SLOTS];
   int          task_cnt;
   int          cur_task;
   bit          cur_valid;
   int          irq_nest;
   int          sem_count [SEMAPHORE_SLOTS];
   int          sem_cnt;
   logic [15:0] ring [QUEUE_SLOTS][QUEUE_DEPTH];
   int          ring_rd [QUEUE_SLOTS];
   int          ring_wr [QUEUE_SLOTS];
   int          ring_len [QUEUE_SLOTS];
   int          ring_cnt;
   bit          did_switch;
   bit          did_fault;

   rsp_word_type expected_rsp [$];
   int           mismatches;
   bit           quiet_phase;
   int           idle_cycles;

   // pick highest ready task unless inside an interrupt
   function automatic void schedule_tasks();
      if (irq_nest != 0) return;
      for (int i = task_cnt; i > 0; i--) begin
         if (task_state[i-1] == ST_READY) begin
            if (!cur_valid || cur_task != i - 1) did_switch = 1'b1;
            cur_task  = i - 1;
            cur_valid = 1'b1;
            return;
         end
      end
      cur_valid = 1'b0;
      cur_task  = 0;
      did_fault = 1'b1;
   endfunction

   function automatic void wake_waiter(logic [1:0] kind, int obj);
      for (int i = task_cnt; i > 0; i--) begin
         if (task_state[i-1] == kind && task_obj[i-1] == obj) begin
            task_state[i-1] = ST_READY;
            return;
         end
      end
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < TASK_SLOTS; i++) begin
         task_state[i] = ST_UNUSED;
         task_obj[i]   = '0;
      end
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         ring_rd[i] = 0;
         ring_wr[i] = 0;
      end
      task_cnt  = 0;
      cur_task  = 0;
      cur_valid = 1'b0;
      irq_nest  = 0;
      sem_cnt   = 0;
      ring_cnt  = 0;
   endfunction

   // apply one request to the model and return the response word
   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type r;
      int obj;
      int v;
      int q;
      obj = w.object_index;
      r = '0;
      did_switch = 1'b0;
      did_fault  = 1'b0;
      case (w.req_type)
         REQ_NEW_TASK: begin
            if (task_cnt >= TASK_SLOTS) did_fault = 1'b1;
            else begin
               r.handle_out = task_cnt[2:0];
               task_state[task_cnt] = ST_READY;
               task_obj[task_cnt] = '0;
               task_cnt++;
            end
         end
         REQ_SEM_NEW: begin
            if (sem_cnt >= SEMAPHORE_SLOTS) did_fault = 1'b1;
            else begin
               r.handle_out = sem_cnt[2:0];
               sem_count[sem_cnt] = $signed(w.init_value);
               sem_cnt++;
            end
         end
         REQ_SEM_POST: begin
            if (obj >= sem_cnt) did_fault = 1'b1;
            else begin
               if (sem_count[obj] < 127) sem_count[obj]++;
               wake_waiter(ST_SEM, obj);
               schedule_tasks();
            end
         end
         REQ_SEM_PEND: begin
            if (obj >= sem_cnt || !cur_valid) did_fault = 1'b1;
            else begin
               v = sem_count[obj];
               if (v > -128) sem_count[obj] = v - 1;
               if (v <= 0) begin
                  task_state[cur_task] = ST_SEM;
                  task_obj[cur_task] = obj[2:0];
                  r.blocked = 1'b1;
                  schedule_tasks();
               end
            end
         end
         REQ_QUE_NEW: begin
            if (ring_cnt >= QUEUE_SLOTS) did_fault = 1'b1;
            else begin
               q = w.new_queue_size;
               if (q == 0) q = 1;
               if (q > QUEUE_DEPTH) q = QUEUE_DEPTH;
               r.handle_out = ring_cnt[2:0];
               ring_len[ring_cnt] = q;
               ring_rd[ring_cnt] = 0;
               ring_wr[ring_cnt] = 0;
               ring_cnt++;
            end
         end
         REQ_QUE_POST: begin
            if (obj >= ring_cnt) did_fault = 1'b1;
            else begin
               q = ring_wr[obj] % QUEUE_DEPTH;
               ring[obj][q] = w.message_in;
               ring_wr[obj] = (q + 1 < ring_len[obj]) ? q + 1 : 0;
               wake_waiter(ST_QUEUE, obj);
               schedule_tasks();
            end
         end
         REQ_QUE_PEND: begin
            if (obj >= ring_cnt || !cur_valid) did_fault = 1'b1;
            else if (ring_rd[obj] == ring_wr[obj]) begin
               task_state[cur_task] = ST_QUEUE;
               task_obj[cur_task] = obj[2:0];
               r.blocked = 1'b1;
               schedule_tasks();
            end else begin
               q = ring_rd[obj] % QUEUE_DEPTH;
               r.message_out = ring[obj][q];
               ring_rd[obj] = (q + 1 < ring_len[obj]) ? q + 1 : 0;
            end
         end
         REQ_ISR_ENTER: if (irq_nest < 255) irq_nest++;
         REQ_ISR_EXIT: begin
            if (irq_nest > 0) irq_nest--;
            schedule_tasks();
         end
         REQ_RUN: schedule_tasks();
         default: ;
      endcase
      r.running_id = cur_valid ? cur_task[2:0] : 3'd0;
      r.running_ok = cur_valid;
      r.switched   = did_switch;
      r.fault      = did_fault;
      return r;
   endfunction

   // send one request word, with random idle before it
   task automatic send_word(req_word_type w);
      while (!quiet_phase && $urandom_range(99) < 14) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_rsp.push_back(predict_rsp(w));
   endtask

   task automatic send_req(logic [3:0] kind, int obj = 0, int ival = 0,
                           int qsize = 1, int msg = 0);
      req_word_type w;
      w.req_type       = kind;
      w.object_index   = obj[2:0];
      w.init_value     = ival[7:0];
      w.new_queue_size = qsize[4:0];
      w.message_in     = msg[15:0];
      send_word(w);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      w.object_index   = 3'($urandom_range(7));
      w.init_value     = 8'($urandom_range(255));
      w.new_queue_size = 5'($urandom_range(31));
      w.message_in     = 16'($urandom_range(65535));
      w.req_type = $urandom_range(99) < 3 ? 4'($urandom_range(15, 10))
                                          : 4'($urandom_range(9));
      if ($urandom_range(9) < 8) w.object_index = 3'($urandom_range(3));
      return w;
   endfunction

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= quiet_phase || ($urandom_range(99) >= 14);
   end

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp.data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp.data.running_id !== e.running_id ||
                rsp.data.running_ok !== e.running_ok ||
                rsp.data.switched !== e.switched ||
                rsp.data.handle_out !== e.handle_out ||
                rsp.data.message_out !== e.message_out ||
                rsp.data.blocked !== e.blocked ||
                rsp.data.fault !== e.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected %h actual %h", $realtime, e,
                           rsp.data);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // empty tables: faults on unknown handles, pend without running task and scheduling with no task; unused codes
   task automatic test_empty_faults();
      send_req(REQ_SEM_POST, 0);
      send_req(REQ_SEM_PEND, 0);
      send_req(REQ_QUE_POST, 7, 0, 1, 16'hffff);
      send_req(REQ_QUE_PEND, 0);
      send_req(REQ_RUN);
      send_req(REQ_ISR_EXIT);
      send_req(4'd15);
      send_req(4'd10);
   endtask

   // creates three tasks, three semaphores and three queues, size clamps, semaphore extremes
   task automatic test_create();
      for (int i = 0; i < 3; i++) send_req(REQ_NEW_TASK);
      send_req(REQ_SEM_NEW, 0, -128);
      send_req(REQ_SEM_NEW, 0, 127);
      send_req(REQ_SEM_NEW, 0, 0);
      send_req(REQ_QUE_NEW, 0, 0, 0);
      send_req(REQ_QUE_NEW, 0, 0, 31);
      send_req(REQ_QUE_NEW, 0, 0, 16);
      send_req(REQ_RUN);
   endtask

   // pend, block, post wakes waiter, isr suppresses scheduling
   task automatic test_sync();
      send_req(REQ_SEM_PEND, 0);
      send_req(REQ_SEM_POST, 1);
      send_req(REQ_QUE_PEND, 2);
      send_req(REQ_ISR_ENTER);
      send_req(REQ_QUE_POST, 2, 0, 1, 16'h0000);
      send_req(REQ_ISR_EXIT);
      send_req(REQ_QUE_PEND, 2);
      send_req(REQ_QUE_POST, 0, 0, 1, 16'hffff);
      send_req(REQ_QUE_PEND, 0);
      send_req(REQ_SEM_POST, 5);
   endtask

   // random traffic; first stretch has no idling
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         quiet_phase = (i < 80);
         send_word(random_word());
      end
      quiet_phase = 1'b0;
   endtask

   // full tables, semaphore posts and pends, then interrupt depth saturation at the top
   task automatic test_saturation();
      for (int i = 0; i < 9; i++) send_req(REQ_NEW_TASK);
      for (int i = 0; i < 9; i++) send_req(REQ_SEM_NEW, 0, 126);
      for (int i = 0; i < 5; i++) send_req(REQ_QUE_NEW, 0, 0, 2);
      send_req(REQ_SEM_POST, 1);
      send_req(REQ_SEM_POST, 1);
      for (int i = 0; i < 4; i++) send_req(REQ_SEM_PEND, 0);
      for (int i = 0; i < 257; i++) send_req(REQ_ISR_ENTER);
      send_req(REQ_RUN);
      send_req(REQ_ISR_EXIT);
   endtask

   initial begin
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.data    = '0;
      mismatches  = 0;
      quiet_phase = 1'b0;
      idle_cycles = 0;
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_faults();
      test_create();
      test_sync();
      test_random(280);
      test_saturation();
      req.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
